// File: rtl/core/overwriting_frame_ring_assert.svh
// Assertion macros used by the frame ring top level.
`ifndef OVERWRITING_FRAME_RING_ASSERT_SVH
`define OVERWRITING_FRAME_RING_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define OFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame ring check failed");

// Next-cycle implication, checked out of reset.
`define OFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame ring check failed");

`endif

// File: rtl/core/ofr_pkg.sv
package ofr_pkg;

    localparam int SLOTS_DEF     = 4;
    localparam int MAX_FRAME_DEF = 64;
    localparam int CFG_W         = 7;
    localparam int LEN_W         = CFG_W + 1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] write_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       empty_res;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW,
        ST_EMPTY
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic write;       // store one byte, advance on frame end
        logic start;       // begin reading the oldest frame
        logic fetch;       // read one byte from the store
        logic step;        // move to the next byte of the frame
        logic finish;      // release the frame just read
        logic show_empty;  // present the empty result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;  // no stored frame
        logic last;   // read position is the frame's final byte
    } status_t;

endpackage

// File: rtl/core/ofr_ctrl.sv
module ofr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_action,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  ofr_pkg::status_t status,
    output ofr_pkg::cmd_t    cmd
);

    ofr_pkg::state_t state_reg;
    ofr_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ofr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ofr_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_action == ofr_pkg::ACT_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else if (status.empty)
                    begin
                        state_next = ofr_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ofr_pkg::ST_FETCH;
                    end
                end
            end
            ofr_pkg::ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ofr_pkg::ST_SHOW;
            end
            ofr_pkg::ST_SHOW:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    if (status.last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ofr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = ofr_pkg::ST_FETCH;
                    end
                end
            end
            ofr_pkg::ST_EMPTY:
            begin
                rsp_valid      = 1'b1;
                cmd.show_empty = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ofr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ofr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/ofr_dp.sv
module ofr_dp #(
    parameter int SLOTS     = ofr_pkg::SLOTS_DEF,
    parameter int MAX_FRAME = ofr_pkg::MAX_FRAME_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [ofr_pkg::CFG_W-1:0] cfg_data,
    input  logic [7:0]                write_byte,
    input  ofr_pkg::cmd_t             cmd,
    output ofr_pkg::status_t          status,
    output ofr_pkg::out_t             rsp_data
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int POS_W  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int DEPTH  = SLOTS * MAX_FRAME;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CFG_W  = ofr_pkg::CFG_W;
    localparam int LEN_W  = ofr_pkg::LEN_W;

    logic [7:0]        frame_mem [DEPTH];
    logic [7:0]        rd_data_reg;

    logic [CFG_W-1:0]  frame_len_reg;
    logic [SLOT_W-1:0] wr_slot_reg;
    logic [SLOT_W-1:0] wr_slot_next;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic [SLOT_W-1:0] rd_slot_next;
    logic [CFG_W-1:0]  bytes_reg;
    logic [CFG_W-1:0]  bytes_next;
    logic [POS_W-1:0]  rd_pos_reg;
    logic [POS_W-1:0]  rd_pos_next;

    logic [CFG_W-1:0]  eff_len;
    logic [POS_W-1:0]  wr_pos;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              frame_done;
    logic [SLOT_W-1:0] wr_slot_adv;

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    // Clamp the configured length into 1..MAX_FRAME
    always_comb
    begin
        priority if (frame_len_reg == '0)
        begin
            eff_len = CFG_W'(1);
        end
        else if (frame_len_reg > CFG_W'(MAX_FRAME))
        begin
            eff_len = CFG_W'(MAX_FRAME);
        end
        else
        begin
            eff_len = frame_len_reg;
        end
    end

    // Store addresses
    assign wr_pos     = (bytes_reg > CFG_W'(MAX_FRAME - 1)) ? POS_W'(MAX_FRAME - 1)
                                                             : POS_W'(bytes_reg);
    assign wr_addr    = ADDR_W'(wr_slot_reg * MAX_FRAME) + ADDR_W'(wr_pos);
    assign rd_addr    = ADDR_W'(rd_slot_reg * MAX_FRAME) + ADDR_W'(rd_pos_reg);
    assign frame_done = (LEN_W'(bytes_reg) + LEN_W'(1)) >= LEN_W'(eff_len);
    assign wr_slot_adv = slot_after(wr_slot_reg);

    // Status toward the controller
    assign status.empty = (wr_slot_reg == rd_slot_reg);
    assign status.last  = (LEN_W'(rd_pos_reg) + LEN_W'(1)) == LEN_W'(eff_len);

    // Index and counter updates
    always_comb
    begin
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        bytes_next   = bytes_reg;
        rd_pos_next  = rd_pos_reg;
        if (cmd.write)
        begin
            if (frame_done)
            begin
                bytes_next   = '0;
                wr_slot_next = wr_slot_adv;
                // Drop the oldest frame when the ring wraps onto it
                if (wr_slot_adv == rd_slot_reg)
                begin
                    rd_slot_next = slot_after(rd_slot_reg);
                end
            end
            else
            begin
                bytes_next = bytes_reg + 1'b1;
            end
        end
        if (cmd.start)
        begin
            rd_pos_next = '0;
        end
        if (cmd.step)
        begin
            rd_pos_next = rd_pos_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            rd_slot_next = slot_after(rd_slot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= CFG_W'(1);
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            bytes_reg     <= '0;
            rd_pos_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_len_reg <= cfg_data;
            end
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            bytes_reg   <= bytes_next;
            rd_pos_reg  <= rd_pos_next;
        end
    end

    // Frame store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            frame_mem[wr_addr] <= write_byte;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    // Result payload
    always_comb
    begin
        if (cmd.show_empty)
        begin
            rsp_data.out_byte  = 8'd0;
            rsp_data.last_byte = 1'b1;
            rsp_data.empty_res = 1'b1;
        end
        else
        begin
            rsp_data.out_byte  = rd_data_reg;
            rsp_data.last_byte = status.last;
            rsp_data.empty_res = 1'b0;
        end
    end

endmodule

// File: rtl/core/overwriting_frame_ring.sv
// Overwriting frame ring: SLOTS slots of frame_length bytes in one store.
// Request channel (req_valid/req_ready/req_data): action 0 writes one frame
// byte, action 1 reads the oldest stored frame. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns the read bytes in order, last_byte
// set on the final one; a read of an empty ring returns one result with
// empty_res and last_byte set. One item is worked on at a time.
// A write transfer is handled in the idle state without leaving it. For
// each byte of a read the controller passes through a fetch state for the
// registered store read and then a show state presenting the byte on the
// response channel, so the first byte is offered after the fetch state that
// follows the request transfer. An empty read goes to the empty state. A full
// ring (SLOTS-1 frames) drops its oldest frame when another is completed.
// When the receiver stalls, the current byte holds on rsp_data and no
// request is taken until the frame has drained. cfg_we/cfg_data set
// frame_length (0 acts as 1, above MAX_FRAME acts as MAX_FRAME); write it
// only while idle. Reset empties the ring and sets frame_length to 1; the
// store itself is not cleared and needs no clearing pass.
module overwriting_frame_ring #(
    parameter int SLOTS     = ofr_pkg::SLOTS_DEF,
    parameter int MAX_FRAME = ofr_pkg::MAX_FRAME_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  ofr_pkg::in_t              req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output ofr_pkg::out_t             rsp_data,
    input  logic                      cfg_we,
    input  logic [ofr_pkg::CFG_W-1:0] cfg_data
);

    `include "overwriting_frame_ring_assert.svh"

    ofr_pkg::cmd_t    cmd;
    ofr_pkg::status_t status;

    ofr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req_data.action),
        .req_ready  (req_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ofr_dp #(
        .SLOTS     (SLOTS),
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .write_byte (req_data.write_byte),
        .cmd        (cmd),
        .status     (status),
        .rsp_data   (rsp_data)
    );

    // Requests are never taken while a result is pending
    `OFR_ASSERT_NOW(a_no_overlap, clk, rst_n, rsp_valid, !req_ready)
    // A frame is released only on its final byte
    `OFR_ASSERT_NOW(a_finish_last, clk, rst_n, cmd.finish, status.last && rsp_ready)
    // In the cycle after an accepted read of a stored frame, the store read is done and no result is offered
    `OFR_ASSERT_NEXT(a_fetch_first, clk, rst_n,
        req_valid && req_ready && req_data.action == ofr_pkg::ACT_READ && !status.empty,
        cmd.fetch && !rsp_valid)
    // An empty result is always a single final result
    `OFR_ASSERT_NOW(a_empty_last, clk, rst_n, rsp_valid && rsp_data.empty_res,
        rsp_data.last_byte && rsp_data.out_byte == 8'd0)

endmodule
